FILE: hw/rtl/gbn_snd_pkg.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender package
// Sequence space, payload width, action and result codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbn_snd_pkg;

    localparam int SEQ_SPACE    = 8;
    localparam int SEQ_W        = 3;
    localparam int PAYLOAD_BITS = 64;
    localparam int WIN_W        = 3;
    localparam int TMR_W        = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    typedef logic [SEQ_W-1:0] t_seq;
    typedef logic [2:0]       t_kind;
    typedef logic [1:0]       t_action;

    localparam t_action ACT_SEND = 2'd0;
    localparam t_action ACT_ACK  = 2'd1;
    localparam t_action ACT_TICK = 2'd2;

    localparam t_kind KIND_SENT    = 3'd0;
    localparam t_kind KIND_REFUSED = 3'd1;
    localparam t_kind KIND_ACK_OK  = 3'd2;
    localparam t_kind KIND_ACK_DROP = 3'd3;
    localparam t_kind KIND_RESEND  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [WIN_W-1:0] WIN_RESET     = 3'd4;
    localparam logic [TMR_W-1:0] TIMEOUT_RESET = 16'd1000;

endpackage

`default_nettype wire

FILE: hw/rtl/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// Go-Back-N sender
// Stores sent payloads by sequence number, tracks the window and the
// retransmit timer, and replays the outstanding words from memory on expiry.
//
//   channel   ports                                   handshake
//   command   i_action, i_message_word, i_ack_*       i_start high, o_busy low
//   result    o_result_kind .. o_last_of_run           o_strobe, one cycle
//   config    i_cfg_idx, i_cfg_data                   i_cfg_we, no wait
//
// Send and ack results appear in the cycle after acceptance; a tick that
// does not expire gives none. An expiring tick replays n outstanding words
// at one per cycle through the single read port of the payload memory:
// o_busy is high while replaying; first word in the cycle after acceptance.
// Reset is synchronous and active low; the payload memory is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_sender_unit
    import gbn_snd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [1:0]               i_action,
    input  wire logic [PAYLOAD_BITS-1:0]  i_message_word,
    input  wire logic [SEQ_W-1:0]         i_ack_number,
    input  wire logic                     i_ack_checksum_ok,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                          o_strobe,
    output logic [2:0]                    o_result_kind,
    output logic [SEQ_W-1:0]              o_sequence_out,
    output logic [PAYLOAD_BITS-1:0]       o_payload_out,
    output logic [SEQ_W-1:0]              o_window_base,
    output logic                          o_window_full,
    output logic                          o_last_of_run
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_REPLAY = 1'b1;

    localparam t_seq             SEQ_MAX = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(SEQ_SPACE - 1);

    logic                     r_state, n_state;
    t_seq                     r_base, n_base;
    t_seq                     r_next, n_next;
    logic                     r_running, n_running;
    logic [TMR_W-1:0]         r_count, n_count;
    logic [WIN_W-1:0]         r_win;
    logic [TMR_W-1:0]         r_timeout;
    t_seq                     r_emit_seq, n_emit_seq;
    t_seq                     r_left, n_left;

    logic                     r_strobe, n_strobe;
    t_kind                    r_kind, n_kind;
    t_seq                     r_seq, n_seq;
    logic [PAYLOAD_BITS-1:0]  r_pay, n_pay;

    logic [PAYLOAD_BITS-1:0]  mem [SEQ_SPACE];
    logic [PAYLOAD_BITS-1:0]  r_mem_q;
    t_seq                     rd_addr;
    logic                     mem_we;

    logic                     accept;
    t_seq                     outstanding;
    logic [WIN_W-1:0]         eff_win;
    logic                     full_now;
    t_seq                     ack_off;
    logic [TMR_W:0]           count_inc;
    logic [TMR_W-1:0]         limit;

    assign accept      = i_start && (r_state == ST_IDLE);
    assign outstanding = r_next - r_base;
    assign eff_win     = (r_win > WIN_MAX) ? WIN_MAX : r_win;
    assign full_now    = ({{(SEQ_W){1'b0}}, outstanding} >= {{(SEQ_W){1'b0}}, SEQ_W'(eff_win)});
    assign ack_off     = i_ack_number - r_base;
    assign count_inc   = {1'b0, r_count} + {{TMR_W{1'b0}}, 1'b1};
    assign limit       = (r_timeout == '0) ? TMR_W'(1) : r_timeout;
    assign rd_addr     = (r_state == ST_REPLAY) ? (r_emit_seq + t_seq'(1)) : r_base;

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_next     = r_next;
        n_running  = r_running;
        n_count    = r_count;
        n_emit_seq = r_emit_seq;
        n_left     = r_left;
        n_strobe   = 1'b0;
        n_kind     = r_kind;
        n_seq      = r_seq;
        n_pay      = r_pay;
        mem_we     = 1'b0;

        if (r_state == ST_REPLAY) begin
            // word read last cycle is on the outputs now
            n_emit_seq = r_emit_seq + t_seq'(1);
            n_left     = r_left - t_seq'(1);
            if (r_left == t_seq'(1)) begin
                n_state = ST_IDLE;
            end
        end else if (accept) begin
            unique case (i_action)
                ACT_SEND: begin
                    n_strobe = 1'b1;
                    if (full_now) begin
                        n_kind = KIND_REFUSED;
                        n_seq  = '0;
                        n_pay  = '0;
                    end else begin
                        mem_we = 1'b1;
                        n_kind = KIND_SENT;
                        n_seq  = r_next;
                        n_pay  = i_message_word;
                        n_next = r_next + t_seq'(1);
                        if (r_base == r_next) begin
                            n_running = 1'b1;
                            n_count   = '0;
                        end
                    end
                end
                ACT_ACK: begin
                    n_strobe = 1'b1;
                    n_seq    = '0;
                    n_pay    = '0;
                    if (!i_ack_checksum_ok || i_ack_number > SEQ_MAX
                        || ack_off >= outstanding) begin
                        n_kind = KIND_ACK_DROP;
                    end else begin
                        n_kind    = KIND_ACK_OK;
                        n_base    = i_ack_number + t_seq'(1);
                        n_running = (n_base != r_next);
                        n_count   = '0;
                    end
                end
                ACT_TICK: begin
                    if (r_running) begin
                        if (count_inc >= {1'b0, limit}) begin
                            n_count = '0;
                            if (outstanding == '0) begin
                                n_running = 1'b0;
                            end else begin
                                n_state    = ST_REPLAY;
                                n_emit_seq = r_base;
                                n_left     = outstanding;
                            end
                        end else begin
                            n_count = count_inc[TMR_W-1:0];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_base    <= '0;
            r_next    <= '0;
            r_running <= 1'b0;
            r_count   <= '0;
            r_win     <= WIN_RESET;
            r_timeout <= TIMEOUT_RESET;
            r_strobe  <= 1'b0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_next    <= n_next;
            r_running <= n_running;
            r_count   <= n_count;
            r_strobe  <= n_strobe;
            r_left    <= n_left;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WINDOW:  r_win     <= i_cfg_data[WIN_W-1:0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[TMR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_seq <= n_emit_seq;
        r_kind     <= n_kind;
        r_seq      <= n_seq;
        r_pay      <= n_pay;
    end

    // payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_next] <= i_message_word;
        end
        r_mem_q <= mem[rd_addr];
    end

    assign o_busy         = (r_state == ST_REPLAY);
    assign o_strobe       = r_strobe || (r_state == ST_REPLAY);
    assign o_result_kind  = (r_state == ST_REPLAY) ? KIND_RESEND : r_kind;
    assign o_sequence_out = (r_state == ST_REPLAY) ? r_emit_seq : r_seq;
    assign o_payload_out  = (r_state == ST_REPLAY) ? r_mem_q : r_pay;
    assign o_window_base  = r_base;
    assign o_window_full  = full_now;
    assign o_last_of_run  = (r_state == ST_REPLAY) ? (r_left == t_seq'(1)) : 1'b1;

endmodule

`default_nettype wire
